// ===== rtl/tridiagonal_system_solver_defines.svh =====
// assertion macros for the tridiagonal system solver
// no dependencies
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH
// implication checked at every clock edge outside reset
`define TSS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TSS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/tss_pkg.sv =====
// shared types and constants for the tridiagonal system solver
// no dependencies
package tss_pkg;
    localparam int MaxRows   = 64;
    localparam int FracBits  = 16;
    localparam int DataW     = 32;
    localparam int AddrW     = $clog2(MaxRows);
    localparam int CountW    = $clog2(MaxRows + 1);
    localparam int QuotW     = DataW + FracBits + 1;

    typedef logic signed [DataW-1:0] word_t;
    typedef logic [AddrW-1:0] addr_t;
    typedef logic [CountW-1:0] count_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FRD,     // read row i (row i-1 is held in registers)
        ST_FDIV,    // factor = lower / diag
        ST_FMUL,    // products with upper and rhs of previous row
        ST_FWB,     // subtract and write back
        ST_BRD,     // read row k
        ST_BMUL,    // upper * x[k+1]
        ST_BDIV,    // (rhs - prod) / diag
        ST_BWB,
        ST_ORD,
        ST_OUT
    } state_t;

    function automatic word_t sat_w(input logic signed [DataW+1:0] v);
        if (v > $signed({{2{1'b0}}, 1'b0, {(DataW-1){1'b1}}}))
            return {1'b0, {(DataW-1){1'b1}}};
        if (v < $signed({{2{1'b1}}, 1'b1, {(DataW-1){1'b0}}}))
            return {1'b1, {(DataW-1){1'b0}}};
        return v[DataW-1:0];
    endfunction

    function automatic word_t q_sub(input word_t a, input word_t b);
        logic signed [DataW+1:0] d;
        d = {{2{a[DataW-1]}}, a} - {{2{b[DataW-1]}}, b};
        return sat_w(d);
    endfunction

    // magnitude (below 2^(DataW+1)) with sign, saturated
    function automatic word_t sat_mag(input logic [DataW:0] m, input logic neg);
        logic signed [DataW+1:0] v;
        v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        return sat_w(v);
    endfunction
endpackage

// ===== rtl/tss_ram.sv =====
// generic single-port-write, single-read ram with registered read
// no dependencies
module tss_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/tss_div.sv =====
// serial restoring divider for q16.16 quotients, round to nearest
// depends on tss_pkg
module tss_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  tss_pkg::word_t num,
    input  tss_pkg::word_t den,
    output logic        done,
    output tss_pkg::word_t quot,
    output logic        div_zero
);
    import tss_pkg::*;
    localparam int NumW = DataW + FracBits;
    localparam int StepW = $clog2(NumW + 1);

    logic [NumW-1:0]   dividend_reg, dividend_next;
    logic [DataW:0]    rem_reg, rem_next;
    logic [DataW-1:0]  dmag_reg;
    logic              neg_reg, busy_reg, busy_next, zero_reg;
    logic [StepW-1:0]  step_reg, step_next;
    logic [DataW:0]    trial;
    logic [DataW:0]    remshift;
    logic [DataW-1:0]  nmag;
    logic [DataW+1:0]  twice_rem;
    logic [DataW:0]    qrnd;

    assign nmag = num[DataW-1] ? DataW'(-num) : DataW'(num);
    assign remshift = {rem_reg[DataW-1:0], dividend_reg[NumW-1]};
    assign trial = remshift - {1'b0, dmag_reg};

    always_comb begin
        dividend_next = dividend_reg;
        rem_next = rem_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        if (busy_reg) begin
            if (!trial[DataW]) begin
                rem_next = trial;
                dividend_next = {dividend_reg[NumW-2:0], 1'b1};
            end else begin
                rem_next = remshift;
                dividend_next = {dividend_reg[NumW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
        end else begin
            if (start) begin
                dividend_reg <= {nmag, {FracBits{1'b0}}};
                rem_reg <= '0;
                dmag_reg <= den[DataW-1] ? DataW'(-den) : DataW'(den);
                neg_reg <= num[DataW-1] ^ den[DataW-1];
                zero_reg <= (den == '0);
                step_reg <= StepW'(NumW);
                busy_reg <= (den != '0);
            end else begin
                dividend_reg <= dividend_next;
                rem_reg <= rem_next;
                busy_reg <= busy_next;
                step_reg <= step_next;
            end
            // zero divisor finishes at once, otherwise on the last step
            done <= start ? (den == '0) : (busy_reg && !busy_next);
        end
    end

    // round: add one when 2*rem >= divisor (ties away from zero)
    assign twice_rem = {rem_reg, 1'b0};
    always_comb begin
        qrnd = (|dividend_reg[NumW-1:DataW+1]) ? {(DataW+1){1'b1}}
                                                : dividend_reg[DataW:0];
        if (twice_rem >= {2'b00, dmag_reg} && !(&qrnd)) qrnd = qrnd + 1'b1;
    end
    assign quot = zero_reg ? '0 : sat_mag(qrnd, neg_reg);
    assign div_zero = zero_reg;
endmodule

// ===== rtl/tridiagonal_system_solver.sv =====
// tridiagonal system solver: row store, thomas elimination, result stream
// depends on tss_pkg, tss_ram, tss_div and tridiagonal_system_solver_defines.svh
//
// Rows enter one per cycle and land in four row memories (lower, diagonal,
// upper, rhs). A request with last_row set starts the solve, during which no
// rows are taken: each row of the forward sweep takes a memory read, read
// data capture and divider launch, a serial division and a multiply and a
// write step; each row of back substitution likewise (read, read data,
// product, division, write). The solve time is set by the shared serial
// divider (a zero divisor ends its division early). Results then leave in
// ascending row order, each through a solution memory read and then a
// registered output stage that holds while m_ready is low. Rows past the
// memory depth are dropped; a zero divisor yields a zero quotient and raises
// zero_pivot on the whole run.
module tridiagonal_system_solver (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tss_pkg::word_t     s_sub_coef,
    input  tss_pkg::word_t     s_diag_coef,
    input  tss_pkg::word_t     s_super_coef,
    input  tss_pkg::word_t     s_rhs,
    input  logic               s_last_row,
    output logic               m_valid,
    input  logic               m_ready,
    output tss_pkg::word_t     m_solution,
    output logic [5:0]         m_row_index,
    output logic               m_last_out,
    output logic               m_zero_pivot
);
    import tss_pkg::*;
`include "tridiagonal_system_solver_defines.svh"

    // control state
    state_t  state_reg, state_next;
    count_t  count_reg, count_next;       // rows stored this run
    addr_t   idx_reg, idx_next;           // current row in the sweeps
    logic    perr_reg, perr_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_last_reg, out_last_next;
    addr_t   out_idx_reg, out_idx_next;

    // datapath registers
    word_t   lo_cur_reg, dg_cur_reg, up_cur_reg, rh_cur_reg;  // row i
    word_t   dg_prv_reg, up_prv_reg, rh_prv_reg;              // row i-1
    word_t   fac_reg, xnext_reg, sol_reg;
    word_t   p1_reg, p2_reg;

    // memory ports
    logic    row_we, dg_we, rh_we, sol_we;
    addr_t   wr_addr, rd_addr, sol_rd_addr;
    word_t   dg_wdata, rh_wdata, sol_wdata;
    word_t   lo_rd, dg_rd, up_rd, rh_rd, sol_rd;

    // shared divider
    logic    div_start, div_done, div_zero;
    word_t   div_num, div_den, div_q;

    logic    accept;

    // read data valid the cycle after a read state; sub_pending_reg follows it in the cycle after
    logic    rd_valid_reg;
    logic    sub_pending_reg;
    // divider launch in back substitution happens once per row
    logic    div_start_issued_reg;
    // back substitution numerator
    word_t   bnum;

    tss_ram #(.Width(DataW), .Depth(MaxRows)) u_lower (
        .aclk, .wr_en(row_we), .wr_addr, .wr_data(s_sub_coef),
        .rd_addr, .rd_data(lo_rd));
    tss_ram #(.Width(DataW), .Depth(MaxRows)) u_diag (
        .aclk, .wr_en(dg_we), .wr_addr, .wr_data(dg_wdata),
        .rd_addr, .rd_data(dg_rd));
    tss_ram #(.Width(DataW), .Depth(MaxRows)) u_upper (
        .aclk, .wr_en(row_we), .wr_addr, .wr_data(s_super_coef),
        .rd_addr, .rd_data(up_rd));
    tss_ram #(.Width(DataW), .Depth(MaxRows)) u_rhs (
        .aclk, .wr_en(rh_we), .wr_addr, .wr_data(rh_wdata),
        .rd_addr, .rd_data(rh_rd));
    tss_ram #(.Width(DataW), .Depth(MaxRows)) u_sol (
        .aclk, .wr_en(sol_we), .wr_addr, .wr_data(sol_wdata),
        .rd_addr(sol_rd_addr), .rd_data(sol_rd));

    tss_div u_div (
        .aclk, .aresetn, .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quot(div_q), .div_zero);

    // q16.16 product, rounded half away from zero, saturated
    function automatic word_t q_mul(input word_t a, input word_t b);
        logic signed [2*DataW-1:0] p;
        logic [2*DataW-1:0] m;
        logic [2*DataW-FracBits-1:0] r;
        p = a * b;
        m = p[2*DataW-1] ? (2*DataW)'(-p) : (2*DataW)'(p);
        r = (2*DataW-FracBits)'((m + (2*DataW)'(1 << (FracBits-1))) >> FracBits);
        return (|r[2*DataW-FracBits-1:DataW+1]) ? sat_mag({(DataW+1){1'b1}}, p[2*DataW-1])
                                                : sat_mag(r[DataW:0], p[2*DataW-1]);
    endfunction

    assign s_ready = (state_reg == ST_LOAD);
    assign accept = s_valid && s_ready;
    assign sol_rd_addr = out_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            idx_reg <= '0;
            perr_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
            out_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            perr_reg <= perr_next;
            out_valid_reg <= out_valid_next;
            out_last_reg <= out_last_next;
            out_idx_reg <= out_idx_next;
        end
    end

    // datapath captures
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_LOAD: begin
                // first row of a run is the previous row for row 1
                if (accept && count_reg == '0) begin
                    dg_prv_reg <= s_diag_coef;
                    up_prv_reg <= s_super_coef;
                    rh_prv_reg <= s_rhs;
                end
            end
            ST_FDIV: begin
                if (div_done) fac_reg <= div_q;
            end
            ST_FMUL: begin
                p1_reg <= q_mul(fac_reg, up_prv_reg);
                p2_reg <= q_mul(fac_reg, rh_prv_reg);
            end
            ST_FWB: begin
                // new row i becomes previous row for i+1
                dg_prv_reg <= q_sub(dg_cur_reg, p1_reg);
                rh_prv_reg <= q_sub(rh_cur_reg, p2_reg);
                up_prv_reg <= up_cur_reg;
            end
            ST_BMUL: p1_reg <= q_mul(up_cur_reg, xnext_reg);
            ST_BDIV: begin
                if (div_done) sol_reg <= div_q;
            end
            ST_BWB: xnext_reg <= sol_reg;
            default: ;
        endcase
        // registered memory data lands in the cycle after the read state
        if (rd_valid_reg) begin
            lo_cur_reg <= lo_rd;
            dg_cur_reg <= dg_rd;
            up_cur_reg <= up_rd;
            rh_cur_reg <= rh_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            sub_pending_reg <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_FRD) || (state_reg == ST_BRD);
            sub_pending_reg <= rd_valid_reg;
        end
    end

    assign bnum = (idx_reg == addr_t'(count_reg - 1'b1)) ? rh_cur_reg
                                                        : q_sub(rh_cur_reg, p1_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        perr_next = perr_reg;
        out_valid_next = out_valid_reg;
        out_last_next = out_last_reg;
        out_idx_next = out_idx_reg;
        row_we = 1'b0;
        dg_we = 1'b0;
        rh_we = 1'b0;
        sol_we = 1'b0;
        wr_addr = addr_t'(count_reg);
        rd_addr = idx_reg;
        dg_wdata = s_diag_coef;
        rh_wdata = s_rhs;
        sol_wdata = sol_reg;
        div_start = 1'b0;
        div_num = lo_cur_reg;
        div_den = dg_prv_reg;

        if (out_valid_reg && m_ready) out_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (count_reg < count_t'(MaxRows)) begin
                        row_we = 1'b1;
                        dg_we = 1'b1;
                        rh_we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_last_row) begin
                        perr_next = 1'b0;
                        if (count_next == count_t'(1)) begin
                            idx_next = '0;
                            state_next = ST_BRD;
                        end else begin
                            idx_next = addr_t'(1);
                            state_next = ST_FRD;
                        end
                    end
                end
            end
            ST_FRD: begin
                state_next = ST_FDIV;
            end
            ST_FDIV: begin
                // row data is captured first, divider starts the cycle after
                if (sub_pending_reg) begin
                    div_start = 1'b1;
                end
                if (div_done) begin
                    if (div_zero) perr_next = 1'b1;
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL: state_next = ST_FWB;
            ST_FWB: begin
                dg_we = 1'b1;
                rh_we = 1'b1;
                wr_addr = idx_reg;
                dg_wdata = q_sub(dg_cur_reg, p1_reg);
                rh_wdata = q_sub(rh_cur_reg, p2_reg);
                if (idx_reg == addr_t'(count_reg - 1'b1)) begin
                    state_next = ST_BRD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_FRD;
                end
            end
            ST_BRD: state_next = ST_BMUL;
            ST_BMUL: begin
                // waits for the captured read data, then registers the product
                if (sub_pending_reg) state_next = ST_BDIV;
            end
            ST_BDIV: begin
                if (!div_start_issued_reg) div_start = 1'b1;
                div_num = bnum;
                div_den = dg_cur_reg;
                if (div_done) begin
                    if (div_zero) perr_next = 1'b1;
                    state_next = ST_BWB;
                end
            end
            ST_BWB: begin
                sol_we = 1'b1;
                wr_addr = idx_reg;
                if (idx_reg == '0) begin
                    out_idx_next = '0;
                    state_next = ST_ORD;
                end else begin
                    idx_next = idx_reg - 1'b1;
                    state_next = ST_BRD;
                end
            end
            ST_ORD: state_next = ST_OUT;    // solution read in flight
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_last_next = (out_idx_reg == addr_t'(count_reg - 1'b1));
                    if (out_last_next) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        out_idx_next = out_idx_reg + 1'b1;
                        state_next = ST_ORD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) div_start_issued_reg <= 1'b0;
        else if (state_reg != ST_BDIV) div_start_issued_reg <= 1'b0;
        else div_start_issued_reg <= 1'b1;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!out_valid_reg || m_ready)) begin
            m_solution <= sol_rd;
            m_row_index <= 6'(out_idx_reg);
            m_zero_pivot <= perr_reg;
        end
    end
    assign m_valid = out_valid_reg;
    assign m_last_out = out_last_reg;

    `TSS_ASSERT_IMP(a_no_load_in_solve, aclk, aresetn,
        state_reg != ST_LOAD, !s_ready, "rows accepted during solve")
    `TSS_ASSERT_IMP(a_count_bound, aclk, aresetn,
        1'b1, count_reg <= count_t'(MaxRows), "row count beyond depth")
    `TSS_ASSERT_NXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_solution), "result dropped")
    `TSS_ASSERT_IMP(a_solve_nonempty, aclk, aresetn,
        state_reg == ST_OUT, count_reg != '0, "solve with no rows")
endmodule
